// File: hw/rtl/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg
// Types and codes shared by the recording mode controller modules.
// ----------------------------------------------------------------------------
package rmc_pkg;

   localparam int unsigned OP_W   = 4;
   localparam int unsigned MODE_W = 3;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned CSR_W  = 32;
   localparam int unsigned CSR_IDX_W = 2;

   // event codes
   localparam logic [OP_W-1:0] OP_TICK       = 4'd0;
   localparam logic [OP_W-1:0] OP_BUTTON     = 4'd1;
   localparam logic [OP_W-1:0] OP_CONNECT    = 4'd2;
   localparam logic [OP_W-1:0] OP_DISCONNECT = 4'd3;
   localparam logic [OP_W-1:0] OP_ERROR      = 4'd4;
   localparam logic [OP_W-1:0] OP_REQ_RECORD = 4'd5;
   localparam logic [OP_W-1:0] OP_REQ_STREAM = 4'd6;
   localparam logic [OP_W-1:0] OP_REQ_IDLE   = 4'd7;
   localparam logic [OP_W-1:0] OP_INIT       = 4'd8;

   // modes
   localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REC    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STREAM = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ERROR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SLEEP  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_RECOVERY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WATCHDOG       = 2'd2;

   localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST   = 32'd60000;
   localparam logic [TIME_W-1:0] ERROR_RECOVERY_RST = 32'd5000;
   localparam logic [TIME_W-1:0] WATCHDOG_RST       = 32'd30000;

   typedef struct packed {
      logic [TIME_W-1:0] idle_timeout_ms;
      logic [TIME_W-1:0] error_recovery_ms;
      logic [TIME_W-1:0] watchdog_timeout_ms;
   } timeout_cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [MODE_W-1:0] previous_mode;
      logic              changed;
      logic              link_up;
      logic              ready_res;
      logic [TIME_W-1:0] time_in_mode;
   } result_type;

endpackage

// File: hw/rtl/rmc_if.sv
// ----------------------------------------------------------------------------
// rmc_if
// Valid/ready channels for events in and results out.
// ----------------------------------------------------------------------------
interface rmc_req_if import rmc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output op, output now_ms, input ready);
   modport sink   (input valid, input op, input now_ms, output ready);
endinterface

interface rmc_rsp_if import rmc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [MODE_W-1:0] previous_mode;
   logic              changed;
   logic              link_up;
   logic              ready_res;
   logic [TIME_W-1:0] time_in_mode;

   modport source (output valid, output mode, output previous_mode, output changed,
                   output link_up, output ready_res, output time_in_mode, input ready);
   modport sink   (input valid, input mode, input previous_mode, input changed,
                   input link_up, input ready_res, input time_in_mode, output ready);
endinterface

// File: hw/rtl/rmc_csr.sv
// ----------------------------------------------------------------------------
// rmc_csr
// Timeout registers, written through a plain write port.
// ----------------------------------------------------------------------------
module rmc_csr import rmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output timeout_cfg_type      cfg
);

   timeout_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IDLE_TIMEOUT:   cfg_in.idle_timeout_ms     = csr_wdata;
            CSR_ERROR_RECOVERY: cfg_in.error_recovery_ms   = csr_wdata;
            CSR_WATCHDOG:       cfg_in.watchdog_timeout_ms = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout_ms     <= IDLE_TIMEOUT_RST;
         cfg_ff.error_recovery_ms   <= ERROR_RECOVERY_RST;
         cfg_ff.watchdog_timeout_ms <= WATCHDOG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/rmc_core.sv
// ----------------------------------------------------------------------------
// rmc_core
// Mode state and the one-event next-state logic.
// ----------------------------------------------------------------------------
module rmc_core import rmc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [OP_W-1:0]   op,
   input  logic [TIME_W-1:0] now_ms,
   input  timeout_cfg_type   cfg,
   output result_type        result
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [MODE_W-1:0] last_ff, last_in;
   logic [TIME_W-1:0] entry_ff, entry_in;
   logic              conn_ff, conn_in;
   logic              init_ff, init_in;

   logic [MODE_W-1:0] target;
   logic [TIME_W-1:0] elapsed;
   logic              chg;

   assign elapsed = now_ms - entry_ff;

   always_comb begin
      mode_in  = mode_ff;
      last_in  = last_ff;
      entry_in = entry_ff;
      conn_in  = conn_ff;
      init_in  = init_ff;
      target   = mode_ff;
      chg      = 1'b0;

      if (op == OP_INIT) begin
         mode_in  = MODE_IDLE;
         last_in  = MODE_IDLE;
         entry_in = '0;
         conn_in  = 1'b0;
         init_in  = 1'b1;
      end else if (init_ff) begin
         unique case (op)
            OP_TICK: begin
               unique case (mode_ff)
                  MODE_IDLE:   if (elapsed >= cfg.idle_timeout_ms)     target = MODE_SLEEP;
                  MODE_ERROR:  if (elapsed >= cfg.error_recovery_ms)   target = MODE_IDLE;
                  MODE_REC,
                  MODE_STREAM: if (elapsed >= cfg.watchdog_timeout_ms) target = MODE_ERROR;
                  default:     target = mode_ff;
               endcase
            end
            OP_BUTTON: begin
               if (mode_ff == MODE_IDLE)        target = MODE_REC;
               else if (mode_ff != MODE_STREAM) target = MODE_IDLE;
            end
            OP_CONNECT: begin
               conn_in = 1'b1;
               if (mode_ff == MODE_REC) target = MODE_STREAM;
            end
            OP_DISCONNECT: begin
               conn_in = 1'b0;
               if (mode_ff == MODE_STREAM) target = MODE_REC;
            end
            OP_ERROR:      target = MODE_ERROR;
            OP_REQ_RECORD: if (mode_ff == MODE_IDLE) target = MODE_REC;
            OP_REQ_STREAM: if (mode_ff == MODE_REC && conn_ff) target = MODE_STREAM;
            OP_REQ_IDLE:   target = MODE_IDLE;
            default:       target = mode_ff;
         endcase

         if (target != mode_ff) begin
            last_in  = mode_ff;
            mode_in  = target;
            entry_in = now_ms;
            chg      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         last_ff  <= MODE_IDLE;
         entry_ff <= '0;
         conn_ff  <= 1'b0;
         init_ff  <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         last_ff  <= last_in;
         entry_ff <= entry_in;
         conn_ff  <= conn_in;
         init_ff  <= init_in;
      end
   end

   assign result.mode          = mode_in;
   assign result.previous_mode = last_in;
   assign result.changed       = chg;
   assign result.link_up       = conn_in;
   assign result.ready_res     = init_in;
   assign result.time_in_mode  = now_ms - entry_in;

endmodule

// File: hw/rtl/recording_mode_controller.sv
// ----------------------------------------------------------------------------
// recording_mode_controller
// Five-mode controller: events in, one status result out per event.
// ----------------------------------------------------------------------------
//  channel   dir  transfer when            payload
//  req_chan  in   valid && ready           op, now_ms
//  rsp_chan  out  valid && ready           mode, previous_mode, changed,
//                                          link_up, ready_res, time_in_mode
//  csr_*     in   csr_write_enable         csr_index, csr_wdata
//
//  One event per cycle sustained while rsp is not stalled; each req transfer
//  passes the event register, then the result register, and rsp valid
//  rises as the result register loads.
//  The mode update is one compare/subtract stage in rmc_core.
//  Synchronous active-high reset; timeouts reset to 60000/5000/30000 ms.
//  A stalled rsp holds the result; req keeps flowing until both stages fill.
// ----------------------------------------------------------------------------
module recording_mode_controller import rmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rmc_req_if.sink              req_chan,
   rmc_rsp_if.source            rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   timeout_cfg_type cfg;
   result_type      result;

   logic              ev_valid_ff, ev_valid_in;
   logic [OP_W-1:0]   ev_op_ff;
   logic [TIME_W-1:0] ev_now_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;

   logic advance;
   logic req_take;

   rmc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   rmc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .op     (ev_op_ff),
      .now_ms (ev_now_ff),
      .cfg    (cfg),
      .result (result)
   );

   // event stage moves into the result register when that one is free
   assign advance        = ev_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !ev_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign ev_valid_in  = req_take || (ev_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ev_op_ff  <= req_chan.op;
         ev_now_ff <= req_chan.now_ms;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.mode          = rsp_data_ff.mode;
   assign rsp_chan.previous_mode = rsp_data_ff.previous_mode;
   assign rsp_chan.changed       = rsp_data_ff.changed;
   assign rsp_chan.link_up       = rsp_data_ff.link_up;
   assign rsp_chan.ready_res     = rsp_data_ff.ready_res;
   assign rsp_chan.time_in_mode  = rsp_data_ff.time_in_mode;

endmodule

// File: verif/recording_mode_controller_tb.sv
// ----------------------------------------------------------------------------
// recording_mode_controller_tb
// Self-checking bench for the five-mode controller. Events are sent with
// random gaps against random result back-pressure. Each status result is
// predicted in-bench from the event stream and the timeout registers, then
// compared field by field. Phases step through several timeout settings.
// ----------------------------------------------------------------------------
module recording_mode_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rmc_pkg::*;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] now_ms;
   } event_type;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   rmc_req_if req_chan ();
   rmc_rsp_if rsp_chan ();

   recording_mode_controller uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // predicted controller state
   logic [MODE_W-1:0] mode_now    = MODE_IDLE;
   logic [MODE_W-1:0] mode_before = MODE_IDLE;
   logic [TIME_W-1:0] entered_ms  = '0;
   logic              link_now    = 1'b0;
   logic              armed       = 1'b0;
   timeout_cfg_type   timeouts    = '{IDLE_TIMEOUT_RST, ERROR_RECOVERY_RST, WATCHDOG_RST};

   event_type   event_backlog[$];
   result_type  status_due[$];
   event_type   next_ev;
   result_type  want;
   logic        req_taken = 1'b0;
   logic [TIME_W-1:0] gen_ms = '0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned calm_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned mismatch_count = 0;

   function automatic bit switch_mode(logic [MODE_W-1:0] target, logic [TIME_W-1:0] now_ms);
      if (target == mode_now) return 1'b0;
      mode_before = mode_now;
      mode_now    = target;
      entered_ms  = now_ms;
      return 1'b1;
   endfunction

   function automatic result_type step_controller(event_type ev);
      logic [TIME_W-1:0] elapsed;
      bit                moved;
      result_type        res;
      moved   = 1'b0;
      elapsed = ev.now_ms - entered_ms;
      if (ev.op == OP_INIT) begin
         mode_now    = MODE_IDLE;
         mode_before = MODE_IDLE;
         entered_ms  = '0;
         link_now    = 1'b0;
         armed       = 1'b1;
      end else if (armed) begin
         case (ev.op)
            OP_TICK: begin
               case (mode_now)
                  MODE_IDLE: begin
                     if (elapsed >= timeouts.idle_timeout_ms)
                        moved = switch_mode(MODE_SLEEP, ev.now_ms);
                  end
                  MODE_ERROR: begin
                     if (elapsed >= timeouts.error_recovery_ms)
                        moved = switch_mode(MODE_IDLE, ev.now_ms);
                  end
                  MODE_REC, MODE_STREAM: begin
                     if (elapsed >= timeouts.watchdog_timeout_ms)
                        moved = switch_mode(MODE_ERROR, ev.now_ms);
                  end
                  default: ;
               endcase
            end
            OP_BUTTON: begin
               if (mode_now == MODE_IDLE) moved = switch_mode(MODE_REC, ev.now_ms);
               else if (mode_now != MODE_STREAM) moved = switch_mode(MODE_IDLE, ev.now_ms);
            end
            OP_CONNECT: begin
               link_now = 1'b1;
               if (mode_now == MODE_REC) moved = switch_mode(MODE_STREAM, ev.now_ms);
            end
            OP_DISCONNECT: begin
               link_now = 1'b0;
               if (mode_now == MODE_STREAM) moved = switch_mode(MODE_REC, ev.now_ms);
            end
            OP_ERROR: moved = switch_mode(MODE_ERROR, ev.now_ms);
            OP_REQ_RECORD: begin
               if (mode_now == MODE_IDLE) moved = switch_mode(MODE_REC, ev.now_ms);
            end
            OP_REQ_STREAM: begin
               if (mode_now == MODE_REC && link_now) moved = switch_mode(MODE_STREAM, ev.now_ms);
            end
            OP_REQ_IDLE: moved = switch_mode(MODE_IDLE, ev.now_ms);
            default: ;
         endcase
      end
      res.mode          = mode_now;
      res.previous_mode = mode_before;
      res.changed       = moved;
      res.link_up       = link_now;
      res.ready_res     = armed;
      res.time_in_mode  = ev.now_ms - entered_ms;
      return res;
   endfunction

   function automatic void check_field(string field, logic [TIME_W-1:0] exp_val,
                                       logic [TIME_W-1:0] got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s expected %0d got %0d", $time, field, exp_val, got_val);
         mismatch_count++;
      end
   endfunction

   // mostly short gaps, a few long ones, none at all during a calm stretch
   function automatic int unsigned gap_len();
      int unsigned pick;
      if (calm_left != 0) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result check first, then prediction for the event transferred at this edge
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (status_due.size() == 0) begin
            $display("%0t: unexpected result: mode %0d changed %0d time_in_mode %0d",
                     $time, rsp_chan.mode, rsp_chan.changed, rsp_chan.time_in_mode);
            mismatch_count++;
         end else begin
            want = status_due.pop_front();
            check_field("mode", TIME_W'(want.mode), TIME_W'(rsp_chan.mode));
            check_field("previous_mode", TIME_W'(want.previous_mode),
                        TIME_W'(rsp_chan.previous_mode));
            check_field("changed", TIME_W'(want.changed), TIME_W'(rsp_chan.changed));
            check_field("link_up", TIME_W'(want.link_up), TIME_W'(rsp_chan.link_up));
            check_field("ready_res", TIME_W'(want.ready_res), TIME_W'(rsp_chan.ready_res));
            check_field("time_in_mode", want.time_in_mode, rsp_chan.time_in_mode);
         end
      end
      if (!reset && req_chan.valid && req_chan.ready)
         status_due.push_back(step_controller(event_type'{req_chan.op, req_chan.now_ms}));
      req_taken <= !reset && req_chan.valid && req_chan.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_taken || !req_chan.valid) begin
         if (send_gap != 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (event_backlog.size() != 0) begin
            next_ev = event_backlog.pop_front();
            req_chan.valid  <= 1'b1;
            req_chan.op     <= next_ev.op;
            req_chan.now_ms <= next_ev.now_ms;
            send_gap = gap_len();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         stall_left = reset ? 0 : gap_len();
      end
   end

   always @(posedge clock) begin
      if (calm_left != 0) calm_left <= calm_left - 1;
      else if ($urandom_range(0, 499) == 0) calm_left <= $urandom_range(40, 200);
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("recording_mode_controller verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_event(logic [OP_W-1:0] op, logic [TIME_W-1:0] now_ms);
      event_backlog.push_back(event_type'{op, now_ms});
      gen_ms = now_ms;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (event_backlog.size() != 0 || req_chan.valid || status_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_IDLE_TIMEOUT:   timeouts.idle_timeout_ms     = value;
         CSR_ERROR_RECOVERY: timeouts.error_recovery_ms   = value;
         CSR_WATCHDOG:       timeouts.watchdog_timeout_ms = value;
         default: ;
      endcase
   endtask

   task automatic apply_timeouts(logic [CSR_W-1:0] idle_ms, logic [CSR_W-1:0] err_ms,
                                 logic [CSR_W-1:0] wd_ms);
      drain();
      write_csr(CSR_IDLE_TIMEOUT, idle_ms);
      write_csr(CSR_ERROR_RECOVERY, err_ms);
      write_csr(CSR_WATCHDOG, wd_ms);
   endtask

   // span sets how far time moves per event relative to the timeouts in force
   task automatic run_random(int unsigned count, logic [TIME_W-1:0] span);
      int unsigned     pick;
      logic [OP_W-1:0] op;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 34) op = OP_TICK;
         else if (pick < 46) op = OP_BUTTON;
         else if (pick < 54) op = OP_CONNECT;
         else if (pick < 62) op = OP_DISCONNECT;
         else if (pick < 67) op = OP_ERROR;
         else if (pick < 76) op = OP_REQ_RECORD;
         else if (pick < 85) op = OP_REQ_STREAM;
         else if (pick < 92) op = OP_REQ_IDLE;
         else if (pick < 95) op = OP_INIT;
         else op = OP_INIT + 4'($urandom_range(1, 7));
         pick = $urandom_range(0, 99);
         // stepping back one ms right after a change gives the largest elapsed time
         if (pick < 60) queue_event(op, gen_ms + $urandom_range(0, span));
         else if (pick < 85) queue_event(op, gen_ms + $urandom_range(0, 3));
         else if (pick < 92) queue_event(op, gen_ms + span * $urandom_range(2, 6));
         else if (pick < 96) queue_event(op, gen_ms - 1);
         else queue_event(op, $urandom);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing moves before init
      queue_event(OP_TICK, 32'd0);
      queue_event(OP_BUTTON, TIME_MAX);
      queue_event(OP_INIT + 4'd7, 32'd100);
      queue_event(OP_INIT, 32'd12345);
      // idle timeout just short, then exact; deep sleep never times out
      queue_event(OP_TICK, 32'd59999);
      queue_event(OP_TICK, 32'd60000);
      queue_event(OP_TICK, TIME_MAX);
      queue_event(OP_BUTTON, 32'd70000);
      queue_event(OP_BUTTON, 32'd70010);
      queue_event(OP_REQ_STREAM, 32'd70020);
      queue_event(OP_CONNECT, 32'd70030);
      queue_event(OP_REQ_RECORD, 32'd70040);
      queue_event(OP_BUTTON, 32'd70050);
      queue_event(OP_DISCONNECT, 32'd70060);
      queue_event(OP_CONNECT, 32'd70070);
      queue_event(OP_INIT + 4'd1, 32'd70080);
      queue_event(OP_TICK, 32'd100070);
      queue_event(OP_ERROR, 32'd100080);
      queue_event(OP_TICK, 32'd105069);
      queue_event(OP_TICK, 32'd105070);
      queue_event(OP_REQ_RECORD, 32'd105100);
      queue_event(OP_REQ_STREAM, 32'd105110);
      queue_event(OP_REQ_IDLE, 32'd105120);
      queue_event(OP_REQ_IDLE, 32'd105130);
      queue_event(OP_ERROR, 32'd105140);
      queue_event(OP_BUTTON, 32'd105150);

      run_random(260, 32'd8000);
      apply_timeouts('0, '0, '0);
      run_random(240, 32'd4);
      apply_timeouts(TIME_MAX, TIME_MAX, TIME_MAX);
      run_random(240, 32'h4000_0000);
      apply_timeouts(32'd50, 32'd20, 32'd100);
      run_random(280, 32'd30);
      apply_timeouts('0, TIME_MAX, 32'd1);
      run_random(240, 32'd10);
      apply_timeouts($urandom_range(1, 2000), $urandom_range(1, 2000), $urandom_range(1, 2000));
      run_random(300, 32'd400);
      apply_timeouts($urandom, $urandom, $urandom);
      run_random(320, 32'h1000_0000);

      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("recording_mode_controller verification clean");
      end else begin
         $display("recording_mode_controller verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/rmc_pkg.sv
hw/rtl/rmc_if.sv
hw/rtl/rmc_csr.sv
hw/rtl/rmc_core.sv
hw/rtl/recording_mode_controller.sv
verif/recording_mode_controller_tb.sv
